@@ rtl/core/sslcm_pkg.sv @@
// Package: shared types and constants for the slot set LCM engine.
`default_nettype none

package sslcm_pkg;

  localparam int unsigned SlotCountDef  = 6;
  localparam int unsigned ResultBitsDef = 31;
  localparam int unsigned ActionW       = 2;
  localparam int unsigned IndexW        = 3;
  localparam int unsigned ValueW        = 17;
  localparam int unsigned InDataW       = ((ActionW + IndexW + ValueW + 7) / 8) * 8;

  typedef enum logic [ActionW-1:0] {
    ACT_SET       = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_CLEAR_ALL = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GCD,
    ST_QUO,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                wr;
    action_e             action;
    logic [IndexW-1:0]   index;
    logic [ValueW-1:0]   value;
  } slot_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/slot_set_lcm_engine.sv @@
// Top level: slot set LCM engine with sequencer around a shared serial divider.
`default_nettype none

// Each input word sets one slot, empties one slot or empties all slots, and
// then yields one output word with the least common multiple of the occupied
// slots, folded from slot 0 up with Euclid's GCD. The block takes one word at
// a time and drops s_axis_tready until the result word has been taken. All
// arithmetic runs through one serial divider of D = max(RESULT_BITS, 17) bits.
// Each occupied nonzero slot takes one division per Euclid step and one more
// for the quotient; an empty slot takes none. With the default six 17-bit
// slots, D = 31. A zero in an occupied slot ends the scan with a zero result;
// once the multiple saturates, later slots are only checked for zero.

module slot_set_lcm_engine #(
  parameter int unsigned SLOT_COUNT  = sslcm_pkg::SlotCountDef,
  parameter int unsigned RESULT_BITS = sslcm_pkg::ResultBitsDef,
  localparam int unsigned OutDataW   = ((RESULT_BITS + 2 + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tdata: action[1:0], slot_index[4:2], resolution_value[21:5], zero pad
  input  wire logic [sslcm_pkg::InDataW-1:0] s_axis_tdata,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: common_multiple, none_present, overflowed, zero pad
  output logic [OutDataW-1:0]                m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready
);

  import sslcm_pkg::*;

  localparam int unsigned DivW  = (RESULT_BITS > ValueW) ? RESULT_BITS : ValueW;
  localparam int unsigned IdxW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CntW  = $clog2(SLOT_COUNT + 1);
  localparam int unsigned ProdW = RESULT_BITS + ValueW;
  localparam int unsigned PadW  = OutDataW - RESULT_BITS - 2;

  state_e state_q, state_d;

  logic [CntW-1:0]        idx_q, idx_d;
  logic [RESULT_BITS-1:0] acc_q, acc_d;
  logic [DivW-1:0]        gb_q, gb_d;
  logic [ProdW-1:0]       prod_q, prod_d;
  logic                   any_q, any_d;
  logic                   zero_q, zero_d;
  logic                   sat_q, sat_d;

  logic                   s_acc;
  slot_cmd_t              cmd;
  logic                   rd_occ;
  logic [ValueW-1:0]      rd_val;
  logic                   scan_end;

  logic                   div_start;
  logic [DivW-1:0]        div_n, div_d;
  logic                   div_busy, div_done;
  logic [DivW-1:0]        div_quot, div_rem;

  logic [RESULT_BITS-1:0] res_val;
  logic                   res_none, res_ovf;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign scan_end = (idx_q == CntW'(SLOT_COUNT));

  always_comb begin
    cmd.wr     = s_acc;
    cmd.action = action_e'(s_axis_tdata[ActionW-1:0]);
    cmd.index  = s_axis_tdata[ActionW +: IndexW];
    cmd.value  = s_axis_tdata[ActionW + IndexW +: ValueW];
  end

  sslcm_slots #(
    .SlotCount(SLOT_COUNT),
    .IdxW     (IdxW)
  ) u_slots (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .rd_idx_i(idx_q[IdxW-1:0]),
    .rd_occ_o(rd_occ),
    .rd_val_o(rd_val)
  );

  sslcm_div #(
    .DataW(DivW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_n),
    .divisor_i (div_d),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_acc) state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_OUT;
        end else if (rd_occ && rd_val == '0) begin
          state_d = ST_OUT;
        end else if (rd_occ && !sat_q) begin
          state_d = ST_GCD;
        end
      end
      ST_GCD:  if (div_done && div_rem == '0) state_d = ST_QUO;
      ST_QUO:  if (div_done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_SCAN;
      ST_OUT:  if (m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake and divider control
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    div_start     = 1'b0;
    div_n         = DivW'(acc_q);
    div_d         = DivW'(rd_val);
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_SCAN: div_start = !scan_end && rd_occ && (rd_val != '0) && !sat_q;
      ST_GCD: begin
        div_start = div_done;
        if (div_rem == '0) begin
          div_n = DivW'(acc_q);
          div_d = gb_q;
        end else begin
          div_n = gb_q;
          div_d = div_rem;
        end
      end
      ST_QUO, ST_MUL: begin
      end
      ST_OUT: m_axis_tvalid = 1'b1;
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    idx_d  = idx_q;
    acc_d  = acc_q;
    gb_d   = gb_q;
    prod_d = prod_q;
    any_d  = any_q;
    zero_d = zero_q;
    sat_d  = sat_q;
    unique case (state_q)
      ST_IDLE: begin
        idx_d  = '0;
        acc_d  = RESULT_BITS'(1);
        any_d  = 1'b0;
        zero_d = 1'b0;
        sat_d  = 1'b0;
      end
      ST_SCAN: begin
        if (!scan_end) begin
          if (rd_occ) begin
            any_d = 1'b1;
            gb_d  = DivW'(rd_val);
            if (rd_val == '0) begin
              zero_d = 1'b1;
            end else if (sat_q) begin
              idx_d = idx_q + CntW'(1);
            end
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end
      end
      ST_GCD: begin
        if (div_done && div_rem != '0) begin
          gb_d = div_rem;
        end
      end
      ST_QUO: begin
        if (div_done) begin
          prod_d = ProdW'(div_quot[RESULT_BITS-1:0]) * ProdW'(rd_val);
        end
      end
      ST_MUL: begin
        idx_d = idx_q + CntW'(1);
        if (prod_q > ProdW'({RESULT_BITS{1'b1}})) begin
          sat_d = 1'b1;
          acc_d = {RESULT_BITS{1'b1}};
        end else begin
          acc_d = prod_q[RESULT_BITS-1:0];
        end
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      any_q   <= 1'b0;
      zero_q  <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      any_q   <= any_d;
      zero_q  <= zero_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    gb_q   <= gb_d;
    prod_q <= prod_d;
  end

  assign res_none = !any_q;
  assign res_val  = (any_q && !zero_q) ? acc_q : '0;
  assign res_ovf  = any_q && !zero_q && sat_q;

  assign m_axis_tdata = {{PadW{1'b0}}, res_ovf, res_none, res_val};

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output sides open together");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready held after accepting a word");

  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_none) |-> (res_val == '0 && !res_ovf))
    else $error("empty slot set gives nonzero result");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sslcm_div.sv @@
// Serial restoring divider: one quotient bit per cycle.
`default_nettype none

module sslcm_div #(
  parameter int unsigned DataW = 31
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DataW-1:0] dividend_i,
  input  wire logic [DataW-1:0] divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [DataW-1:0]      quot_o,
  output logic [DataW-1:0]      rem_o
);

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DataW:0]   rem_sh;
  logic [DataW:0]   diff;

  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DataW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DataW]) begin
        rem_d = diff[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ rtl/core/sslcm_slots.sv @@
// Slot register file: values and occupied bits, updated by set and empty commands.
`default_nettype none

module sslcm_slots #(
  parameter int unsigned SlotCount = 6,
  parameter int unsigned IdxW      = 3
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sslcm_pkg::slot_cmd_t        cmd_i,
  input  wire logic [IdxW-1:0]             rd_idx_i,
  output logic                             rd_occ_o,
  output logic [sslcm_pkg::ValueW-1:0]     rd_val_o
);

  import sslcm_pkg::*;

  logic [ValueW-1:0]    val_q [SlotCount];
  logic [SlotCount-1:0] occ_q, occ_d;
  logic [SlotCount-1:0] set_hit;

  always_comb begin
    occ_d   = occ_q;
    set_hit = '0;
    if (cmd_i.wr) begin
      unique case (cmd_i.action)
        ACT_SET: begin
          for (int i = 0; i < SlotCount; i++) begin
            if (32'(cmd_i.index) == i) begin
              occ_d[i]   = 1'b1;
              set_hit[i] = 1'b1;
            end
          end
        end
        ACT_CLEAR: begin
          for (int i = 0; i < SlotCount; i++) begin
            if (32'(cmd_i.index) == i) begin
              occ_d[i] = 1'b0;
            end
          end
        end
        ACT_CLEAR_ALL: occ_d = '0;
        default: occ_d = occ_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SlotCount; i++) begin
      if (set_hit[i]) begin
        val_q[i] <= cmd_i.value;
      end
    end
  end

  assign rd_occ_o = occ_q[rd_idx_i];
  assign rd_val_o = val_q[rd_idx_i];

endmodule

`default_nettype wire

@@ tb/sv/slot_lcm_checker.sv @@
// Checker: watches both word channels, predicts each LCM result word and compares it.
module slot_lcm_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cmd_tdata: action[1:0], slot_index[4:2], resolution_value[21:5], zero pad
  input  logic [sslcm_pkg::InDataW-1:0] cmd_tdata_i,
  input  logic                          cmd_tvalid_i,
  input  logic                          cmd_tready_i,
  // res_tdata: common_multiple[30:0], none_present[31], overflowed[32], zero pad
  input  logic [39:0]                   res_tdata_i,
  input  logic                          res_tvalid_i,
  input  logic                          res_tready_i,
  output int                            fails_o,
  output int                            pending_o,
  output int                            checked_o,
  output int                            saturated_o,
  output int                            empty_set_o,
  output int                            zeroed_o
);

  import sslcm_pkg::*;

  localparam int unsigned ResW   = ResultBitsDef;
  localparam logic [63:0] ResMax = (64'd1 << ResW) - 64'd1;

  typedef struct packed {
    logic            ovf;
    logic            none;
    logic [ResW-1:0] multiple;
  } lcm_word_t;

  logic [ValueW-1:0] slot_val  [SlotCountDef];
  logic              slot_used [SlotCountDef];
  lcm_word_t         lcm_expect_q [$];
  int                fails, checked, saturated, empty_set, zeroed;

  function automatic logic [63:0] euclid_gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    while (b != 64'd0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic lcm_word_t predict_lcm_word(logic [ActionW-1:0] act,
                                                 logic [IndexW-1:0] idx,
                                                 logic [ValueW-1:0] val);
    lcm_word_t   w;
    logic [63:0] acc, q, v;
    logic        any_used, zero_used, sat;
    int          i;
    acc       = 64'd1;
    any_used  = 1'b0;
    zero_used = 1'b0;
    sat       = 1'b0;
    if (act == ACT_SET && idx < SlotCountDef) begin
      slot_val[idx]  = val;
      slot_used[idx] = 1'b1;
    end else if (act == ACT_CLEAR && idx < SlotCountDef) begin
      slot_used[idx] = 1'b0;
    end else if (act == ACT_CLEAR_ALL) begin
      for (i = 0; i < SlotCountDef; i++) slot_used[i] = 1'b0;
    end
    for (i = 0; i < SlotCountDef; i++) begin
      if (slot_used[i]) begin
        any_used = 1'b1;
        v = 64'(slot_val[i]);
        if (v == 64'd0) begin
          zero_used = 1'b1;
        end else if (!sat && !zero_used) begin
          q = acc / euclid_gcd64(acc, v);
          if (q > ResMax / v) begin
            sat = 1'b1;
            acc = ResMax;
          end else begin
            acc = q * v;
          end
        end
      end
    end
    w.none     = !any_used;
    w.ovf      = any_used && !zero_used && sat;
    w.multiple = (any_used && !zero_used) ? acc[ResW-1:0] : '0;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    lcm_word_t want, got, next_word;
    if (!rst_ni) begin
      for (int i = 0; i < SlotCountDef; i++) begin
        slot_val[i]  = '0;
        slot_used[i] = 1'b0;
      end
      lcm_expect_q.delete();
      fails     = 0;
      checked   = 0;
      saturated = 0;
      empty_set = 0;
      zeroed    = 0;
    end else begin
      if (cmd_tvalid_i && cmd_tready_i) begin
        next_word = predict_lcm_word(cmd_tdata_i[ActionW-1:0],
            cmd_tdata_i[ActionW+IndexW-1:ActionW],
            cmd_tdata_i[ActionW+IndexW+ValueW-1:ActionW+IndexW]);
        lcm_expect_q.insert(lcm_expect_q.size(), next_word);
      end
      if (res_tvalid_i && res_tready_i) begin
        got = res_tdata_i[ResW+1:0];
        if (lcm_expect_q.size() == 0) begin
          if (fails < 10)
            $display("%0t: result word with nothing expected: %0d none %0b ovf %0b",
                     $time, got.multiple, got.none, got.ovf);
          fails++;
        end else begin
          want = lcm_expect_q.pop_front();
          checked++;
          if (want.ovf) saturated++;
          if (want.none) empty_set++;
          if (!want.none && !want.ovf && want.multiple == '0) zeroed++;
          if (got.multiple !== want.multiple || got.none !== want.none ||
              got.ovf !== want.ovf) begin
            if (fails < 10)
              $display({"%0t: mismatch: expected multiple %0d none %0b ovf %0b,",
                        " got multiple %0d none %0b ovf %0b"},
                       $time, want.multiple, want.none, want.ovf,
                       got.multiple, got.none, got.ovf);
            fails++;
          end
        end
      end
    end
    fails_o     <= fails;
    pending_o   <= lcm_expect_q.size();
    checked_o   <= checked;
    saturated_o <= saturated;
    empty_set_o <= empty_set;
    zeroed_o    <= zeroed;
  end

endmodule

@@ tb/sv/tb_slot_set_lcm_engine.sv @@
// Testbench top: drives slot commands into the LCM engine and reports the verdict.
module tb_slot_set_lcm_engine;
  import sslcm_pkg::*;

  localparam int unsigned OutW       = ((ResultBitsDef + 2 + 7) / 8) * 8;
  localparam logic [ActionW-1:0] ActUnused = 2'd3;
  localparam int          RandItems  = 115;
  localparam int          CalmItems  = 25;
  localparam int          IdleLimit  = 20000;
  localparam int          DrainCycles = 4500;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  // s_axis_tdata: action[1:0], slot_index[4:2], resolution_value[21:5], zero pad
  logic [InDataW-1:0] s_axis_tdata;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  // m_axis_tdata: common_multiple[30:0], none_present[31], overflowed[32], zero pad
  logic [OutW-1:0]    m_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;

  logic calm = 1'b0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   cmds_sent = 0;
  int   directed_cnt;
  int   fails, pending, checked, saturated, empty_set, zeroed;

  slot_set_lcm_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  slot_lcm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_tdata_i  (s_axis_tdata),
    .cmd_tvalid_i (s_axis_tvalid),
    .cmd_tready_i (s_axis_tready),
    .res_tdata_i  (m_axis_tdata),
    .res_tvalid_i (m_axis_tvalid),
    .res_tready_i (m_axis_tready),
    .fails_o      (fails),
    .pending_o    (pending),
    .checked_o    (checked),
    .saturated_o  (saturated),
    .empty_set_o  (empty_set),
    .zeroed_o     (zeroed)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 9);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Watchdog: no word moved for %0d cycles", IdleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue_cmd(input logic [ActionW-1:0] act, input logic [IndexW-1:0] idx,
                           input logic [ValueW-1:0] val);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - ActionW - IndexW - ValueW){1'b0}}, val, idx, act};
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    cmds_sent++;
  endtask

  initial begin
    int                pick;
    logic [ActionW-1:0] act;
    logic [IndexW-1:0]  idx;
    logic [ValueW-1:0]  val;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    issue_cmd(ACT_CLEAR_ALL, 3'd0, 17'd0);
    issue_cmd(ACT_SET,       3'd0, 17'd1);
    issue_cmd(ACT_SET,       3'd5, 17'h1FFFF);
    issue_cmd(ACT_SET,       3'd1, 17'd86400);
    issue_cmd(ACT_SET,       3'd3, 17'd0);
    issue_cmd(ACT_CLEAR,     3'd3, 17'd0);
    issue_cmd(ACT_SET,       3'd6, 17'd5);
    issue_cmd(ACT_CLEAR,     3'd7, 17'd0);
    issue_cmd(ActUnused,     3'd0, 17'h1FFFF);
    issue_cmd(ACT_CLEAR,     3'd5, 17'd0);
    issue_cmd(ACT_CLEAR_ALL, 3'd7, 17'h1FFFF);
    issue_cmd(ACT_SET,       3'd0, 17'd12);
    issue_cmd(ACT_SET,       3'd1, 17'd18);
    issue_cmd(ACT_SET,       3'd2, 17'd7);
    issue_cmd(ACT_SET,       3'd3, 17'd131071);
    issue_cmd(ACT_SET,       3'd4, 17'd131070);
    issue_cmd(ACT_SET,       3'd4, 17'd0);
    issue_cmd(ACT_SET,       3'd5, 17'd0);
    issue_cmd(ACT_CLEAR,     3'd4, 17'd0);
    issue_cmd(ACT_CLEAR,     3'd5, 17'd0);
    issue_cmd(ACT_SET,       3'd4, 17'h0AAAA);
    issue_cmd(ACT_SET,       3'd5, 17'h15555);
    issue_cmd(ACT_CLEAR,     3'd0, 17'd0);
    issue_cmd(ActUnused,     3'd6, 17'd0);
    issue_cmd(ACT_CLEAR_ALL, 3'd2, 17'd0);
    directed_cnt = cmds_sent;

    for (int n = 0; n < RandItems; n++) begin
      calm = (n >= RandItems - CalmItems);
      pick = $urandom_range(0, 99);
      idx  = IndexW'($urandom_range(0, SlotCountDef - 1));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: val = ValueW'($urandom_range(1, 60));
        4, 5: begin
          case ($urandom_range(0, 7))
            0:       val = 17'd60;
            1:       val = 17'd300;
            2:       val = 17'd900;
            3:       val = 17'd3600;
            4:       val = 17'd7200;
            5:       val = 17'd43200;
            6:       val = 17'd86400;
            default: val = 17'd1;
          endcase
        end
        6, 7: val = ValueW'($urandom_range(1, 86400));
        8:    val = ValueW'($urandom_range(0, 131071));
        default: val = ($urandom_range(0, 2) == 0) ? 17'd0 :
                       ValueW'($urandom_range(86401, 131071));
      endcase
      if (pick < 62) begin
        act = ACT_SET;
      end else if (pick < 80) begin
        act = ACT_CLEAR;
      end else if (pick < 86) begin
        act = ACT_CLEAR_ALL;
      end else if (pick < 92) begin
        act = ActUnused;
      end else begin
        act = ($urandom_range(0, 1) == 0) ? ACT_SET : ACT_CLEAR;
        idx = IndexW'($urandom_range(SlotCountDef, 7));
      end
      issue_cmd(act, idx, val);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d slot commands (%0d directed, rest random), %0d results checked.",
             cmds_sent, directed_cnt, checked);
    $display("Of those, %0d saturated, %0d had every slot empty, %0d were zeroed by a zero slot.",
             saturated, empty_set, zeroed);
    if (fails == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
